FILE: rtl/rcfu_pkg.sv
package rcfu_pkg;

  // Default sizes for the top-level parameters.
  localparam int NPOLES_DEF = 2;
  localparam int CELLS_DEF  = 1024;

  // Operation codes carried in the mode field.
  localparam logic [1:0] MODE_SAVE   = 2'd0;
  localparam logic [1:0] MODE_UPDATE = 2'd1;
  localparam logic [1:0] MODE_APPLY  = 2'd2;

  // Component code that selects nothing.
  localparam logic [1:0] COMP_NONE = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_RECUR0  = 3'd0;
  localparam logic [2:0] REG_RECUR1  = 3'd1;
  localparam logic [2:0] REG_DRIVE0  = 3'd2;
  localparam logic [2:0] REG_DRIVE1  = 3'd3;
  localparam logic [2:0] REG_FLUXG   = 3'd4;
  localparam logic [2:0] REG_MEMG    = 3'd5;

  // Reset value of the memory gain: 1.0 in Q8.24.
  localparam logic [31:0] MEMG_RESET = 32'h0100_0000;

  localparam logic [31:0] Q32_MAX = 32'h7fff_ffff;
  localparam logic [31:0] Q32_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [1:0]         mode;
    logic [9:0]         cell_index;
    logic signed [31:0] field_x;
    logic signed [31:0] field_y;
    logic signed [31:0] field_z;
    logic [1:0]         component;
    logic signed [31:0] flux_value;
    logic signed [31:0] field_now;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] field_new;
    logic               saturated;
  } out_item_t;

  // Clipped value and its clip flag.
  typedef struct packed {
    logic signed [31:0] val;
    logic               sat;
  } clip_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SAVE,
    ST_RD,
    ST_MUL,
    ST_RNDR,
    ST_WR,
    ST_F1,
    ST_F2,
    ST_F3,
    ST_SRD,
    ST_SACC,
    ST_S2,
    ST_M1,
    ST_M2,
    ST_OUT
  } state_t;

  // Round a Q.48 product sum to Q.24 (add half, floor shift) and clip to 32 bits.
  function automatic clip_t round_clip(input logic signed [63:0] x);
    logic signed [63:0] y;
    clip_t              r;
    y = (x + 64'sd8388608) >>> 24;
    r.sat = !((&y[63:31]) || !(|y[63:31]));
    r.val = r.sat ? (y[63] ? Q32_MIN : Q32_MAX) : y[31:0];
    return r;
  endfunction

  // Add two 32-bit values and clip the result to 32 bits.
  function automatic clip_t add_clip(input logic signed [31:0] a,
                                     input logic signed [31:0] b);
    logic [32:0] s;
    clip_t       r;
    s = {a[31], a} + {b[31], b};
    r.sat = s[32] ^ s[31];
    r.val = r.sat ? (s[32] ? Q32_MIN : Q32_MAX) : s[31:0];
    return r;
  endfunction

endpackage

FILE: rtl/rcfu_ram.sv
module rcfu_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/recursive_convolution_field_update_top.sv
// Each item keeps busy high while it runs: mode 0 (save), mode 1 (update), which steps every
// accumulator on the single shared 32x32 multiplier, and mode 2 (apply), whose item strobes
// on out_valid in the same cycle that busy falls. No result is ever held back. Ignored items
// (bad mode, component or cell) leave the block idle. After reset the accumulator memory is
// swept to zero, one entry a cycle, with busy high; configuration writes are taken during
// the sweep. rst_n is synchronous, active low.
module recursive_convolution_field_update_top #(
  parameter int NPOLES = rcfu_pkg::NPOLES_DEF,
  parameter int CELLS  = rcfu_pkg::CELLS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // Command channel.
  input  logic                start,
  output logic                busy,
  input  rcfu_pkg::in_item_t  in_data,
  // Result channel.
  output logic                out_valid,
  output rcfu_pkg::out_item_t out_data,
  // Configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [5:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready
);

  import rcfu_pkg::*;

  localparam int ACC_STRIDE = NPOLES * 3;
  localparam int ACC_DEPTH  = CELLS * ACC_STRIDE;
  localparam int AAW        = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;
  localparam int SF_DEPTH   = CELLS * 3;
  localparam int SAW        = (SF_DEPTH > 1) ? $clog2(SF_DEPTH) : 1;
  localparam int PW         = (NPOLES > 1) ? $clog2(NPOLES) : 1;
  localparam int SSW        = 32 + PW;

  // Configuration registers.
  logic [63:0]        recur0_r, recur1_r, drive0_r, drive1_r;
  logic signed [31:0] flux_gain_r, memory_gain_r;

  // Sequencer and datapath registers.
  state_t             state_r, state_nxt;
  in_item_t           item_r;
  logic [PW-1:0]      p_r;
  logic [1:0]         c_r;
  logic [2:0]         k_r;
  logic [AAW-1:0]     acc_addr_r;
  logic [SAW-1:0]     sf_base_r;
  logic signed [63:0] prod_r;
  logic signed [63:0] sum_re_r, sum_im_r;
  logic signed [31:0] nr_r, t_r, a_r, s_r;
  logic signed [SSW-1:0] ssum_r;
  logic               sat_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  // Memory ports.
  logic               acc_we, acc_re, sf_we, sf_re;
  logic [63:0]        acc_wdata, acc_rd;
  logic [31:0]        sf_wdata, sf_rd;
  logic [SAW-1:0]     sf_addr;

  // Shared multiplier operands.
  logic signed [31:0] mul_a, mul_b;
  logic [63:0]        rc_sel, dc_sel;
  logic [2:0]         j;
  logic signed [63:0] term;
  logic               cell_ok, cfg_wr;
  clip_t              rc_im, rc_gen, ac_res;
  logic               ss_ov;

  // Configuration write and read.
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recur0_r      <= '0;
      recur1_r      <= '0;
      drive0_r      <= '0;
      drive1_r      <= '0;
      flux_gain_r   <= '0;
      memory_gain_r <= MEMG_RESET;
    end else if (cfg_wr) begin
      case (paddr[5:3])
        REG_RECUR0: recur0_r      <= pwdata;
        REG_RECUR1: recur1_r      <= pwdata;
        REG_DRIVE0: drive0_r      <= pwdata;
        REG_DRIVE1: drive1_r      <= pwdata;
        REG_FLUXG:  flux_gain_r   <= pwdata[31:0];
        REG_MEMG:   memory_gain_r <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[5:3])
      REG_RECUR0: prdata = recur0_r;
      REG_RECUR1: prdata = recur1_r;
      REG_DRIVE0: prdata = drive0_r;
      REG_DRIVE1: prdata = drive1_r;
      REG_FLUXG:  prdata = {32'd0, flux_gain_r};
      REG_MEMG:   prdata = {32'd0, memory_gain_r};
      default:    prdata = '0;
    endcase
  end

  // Memories for the saved fields and the pole accumulators.
  rcfu_ram #(.WIDTH(32), .DEPTH(SF_DEPTH), .ADDR_W(SAW)) u_sf_ram (
    .clk   (clk),
    .we    (sf_we),
    .waddr (sf_addr),
    .wdata (sf_wdata),
    .re    (sf_re),
    .raddr (sf_addr),
    .rdata (sf_rd)
  );

  rcfu_ram #(.WIDTH(64), .DEPTH(ACC_DEPTH), .ADDR_W(AAW)) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_addr_r),
    .wdata (acc_wdata),
    .re    (acc_re),
    .raddr (acc_addr_r),
    .rdata (acc_rd)
  );

  assign sf_addr = sf_base_r + SAW'(c_r);

  always_comb begin
    case (c_r)
      2'd0:    sf_wdata = item_r.field_x;
      2'd1:    sf_wdata = item_r.field_y;
      default: sf_wdata = item_r.field_z;
    endcase
  end

  // Coefficients of the current pole; poles past the second use zero.
  always_comb begin
    rc_sel = '0;
    dc_sel = '0;
    if (32'(p_r) == 0) begin
      rc_sel = recur0_r;
      dc_sel = drive0_r;
    end else if (32'(p_r) == 1) begin
      rc_sel = recur1_r;
      dc_sel = drive1_r;
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = flux_gain_r;
    mul_b = item_r.flux_value;
    if (state_r == ST_M1) begin
      mul_a = memory_gain_r;
      mul_b = s_r;
    end else if (state_r == ST_MUL) begin
      case (k_r)
        3'd0: begin
          mul_a = rc_sel[31:0];
          mul_b = acc_rd[31:0];
        end
        3'd1: begin
          mul_a = rc_sel[63:32];
          mul_b = acc_rd[63:32];
        end
        3'd2: begin
          mul_a = dc_sel[31:0];
          mul_b = sf_rd;
        end
        3'd3: begin
          mul_a = rc_sel[31:0];
          mul_b = acc_rd[63:32];
        end
        3'd4: begin
          mul_a = rc_sel[63:32];
          mul_b = acc_rd[31:0];
        end
        default: begin
          mul_a = dc_sel[63:32];
          mul_b = sf_rd;
        end
      endcase
    end
  end

  // Product of the previous step, floor-shifted to Q.48.
  assign j    = k_r - 3'd1;
  assign term = prod_r >>> 6;

  assign rc_im  = round_clip(sum_im_r);
  assign rc_gen = round_clip((state_r == ST_RNDR) ? sum_re_r : prod_r);
  assign ac_res = add_clip((state_r == ST_OUT) ? a_r : item_r.field_now, t_r);
  assign ss_ov  = !((&ssum_r[SSW-1:31]) || !(|ssum_r[SSW-1:31]));

  assign cell_ok = {22'd0, in_data.cell_index} < 32'(CELLS);

  // Memory controls.
  assign sf_we     = (state_r == ST_SAVE);
  assign sf_re     = (state_r == ST_RD);
  assign acc_re    = (state_r == ST_RD) || (state_r == ST_SRD);
  assign acc_we    = (state_r == ST_CLEAR) || (state_r == ST_WR);
  assign acc_wdata = (state_r == ST_WR) ? {rc_im.val, nr_r} : 64'd0;

  // Sequencer: next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (acc_addr_r == AAW'(ACC_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start && cell_ok) begin
          case (in_data.mode)
            MODE_SAVE:   state_nxt = ST_SAVE;
            MODE_UPDATE: state_nxt = ST_RD;
            MODE_APPLY: begin
              if (in_data.component != COMP_NONE) begin
                state_nxt = ST_F1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SAVE: begin
        if (c_r == 2'd2) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RD:   state_nxt = ST_MUL;
      ST_MUL: begin
        if (k_r == 3'd6) begin
          state_nxt = ST_RNDR;
        end
      end
      ST_RNDR: state_nxt = ST_WR;
      ST_WR: begin
        if (p_r == PW'(NPOLES - 1) && c_r == 2'd2) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_F1:   state_nxt = ST_F2;
      ST_F2:   state_nxt = ST_F3;
      ST_F3:   state_nxt = ST_SRD;
      ST_SRD:  state_nxt = ST_SACC;
      ST_SACC: begin
        if (p_r == PW'(NPOLES - 1)) begin
          state_nxt = ST_S2;
        end else begin
          state_nxt = ST_SRD;
        end
      end
      ST_S2:   state_nxt = ST_M1;
      ST_M1:   state_nxt = ST_M2;
      ST_M2:   state_nxt = ST_OUT;
      ST_OUT:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      acc_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_OUT);
      case (state_r)
        ST_CLEAR: acc_addr_r <= acc_addr_r + AAW'(1);
        ST_IDLE: begin
          if (in_data.mode == MODE_APPLY) begin
            acc_addr_r <= AAW'(32'(in_data.cell_index) * ACC_STRIDE)
                        + AAW'(in_data.component);
          end else begin
            acc_addr_r <= AAW'(32'(in_data.cell_index) * ACC_STRIDE);
          end
        end
        ST_WR:   acc_addr_r <= acc_addr_r + AAW'(1);
        ST_SACC: acc_addr_r <= acc_addr_r + AAW'(3);
        default: ;
      endcase
    end
  end

  // Datapath registers and loop counters.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        item_r    <= in_data;
        sf_base_r <= SAW'(32'(in_data.cell_index) * 3);
        p_r       <= '0;
        c_r       <= '0;
        k_r       <= '0;
        sat_r     <= 1'b0;
        ssum_r    <= '0;
      end
      ST_SAVE: c_r <= c_r + 2'd1;
      ST_RD:   k_r <= '0;
      ST_MUL: begin
        k_r <= k_r + 3'd1;
        if (k_r != 3'd6) begin
          prod_r <= mul_a * mul_b;
        end
        if (k_r == 3'd0) begin
          sum_re_r <= '0;
          sum_im_r <= '0;
        end else if (j == 3'd1) begin
          sum_re_r <= sum_re_r - term;
        end else if (j < 3'd3) begin
          sum_re_r <= sum_re_r + term;
        end else begin
          sum_im_r <= sum_im_r + term;
        end
      end
      ST_RNDR: nr_r <= rc_gen.val;
      ST_WR: begin
        if (c_r == 2'd2) begin
          c_r <= '0;
          p_r <= p_r + PW'(1);
        end else begin
          c_r <= c_r + 2'd1;
        end
      end
      ST_F1: prod_r <= mul_a * mul_b;
      ST_F2: begin
        t_r   <= rc_gen.val;
        sat_r <= sat_r | rc_gen.sat;
      end
      ST_F3: begin
        a_r   <= ac_res.val;
        sat_r <= sat_r | ac_res.sat;
      end
      ST_SACC: begin
        ssum_r <= ssum_r + {{(SSW-32){acc_rd[31]}}, acc_rd[31:0]};
        p_r    <= p_r + PW'(1);
      end
      ST_S2: begin
        s_r   <= ss_ov ? (ssum_r[SSW-1] ? Q32_MIN : Q32_MAX) : ssum_r[31:0];
        sat_r <= sat_r | ss_ov;
      end
      ST_M1: prod_r <= mul_a * mul_b;
      ST_M2: begin
        t_r   <= rc_gen.val;
        sat_r <= sat_r | rc_gen.sat;
      end
      ST_OUT: begin
        out_data_r.field_new <= ac_res.val;
        out_data_r.saturated <= sat_r | ac_res.sat;
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: tb/rcfu_tb_pkg.sv
package rcfu_tb_pkg;
  import rcfu_pkg::*;

  // Tracks the register and cell state of the block, predicts the updated field of every
  // accepted apply item and checks results in order.
  class field_update_scoreboard;
    logic [63:0] recur_coef [2];
    logic [63:0] drive_coef [2];
    int          flux_gain;
    int          memory_gain;

    int saved_field [CELLS_DEF*3];
    int acc_re      [CELLS_DEF*NPOLES_DEF*3];
    int acc_im      [CELLS_DEF*NPOLES_DEF*3];
    bit cell_saved  [CELLS_DEF];

    out_item_t field_expected [$];
    bit        clip_seen;
    int        n_saves, n_updates, n_applies, n_dropped;
    int        n_checked, n_clipped, n_errors;

    function new();
      recur_coef[0] = '0;
      recur_coef[1] = '0;
      drive_coef[0] = '0;
      drive_coef[1] = '0;
      flux_gain     = 0;
      memory_gain   = MEMG_RESET;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] val);
      case (idx)
        REG_RECUR0: recur_coef[0] = val;
        REG_RECUR1: recur_coef[1] = val;
        REG_DRIVE0: drive_coef[0] = val;
        REG_DRIVE1: drive_coef[1] = val;
        REG_FLUXG:  flux_gain     = val[31:0];
        REG_MEMG:   memory_gain   = val[31:0];
        default: ;
      endcase
    endfunction

    function longint coef_half(logic [31:0] h);
      return longint'($signed(h));
    endfunction

    // Saturate to 32 bits and remember that a clip happened.
    function int clamp32(longint x);
      if (x > 64'sd2147483647) begin
        clip_seen = 1'b1;
        return 32'sh7fff_ffff;
      end
      if (x < -64'sd2147483648) begin
        clip_seen = 1'b1;
        return 32'sh8000_0000;
      end
      return int'(x);
    endfunction

    // Drop 24 fraction bits with round half up, then saturate.
    function int round24(longint x);
      return clamp32((x + 64'sd8388608) >>> 24);
    endfunction

    // Advance every pole accumulator of one cell by one step.
    function void update_cell(int cell_id);
      longint cr, ci, dr, di, ar, ai, e, sr, si;
      int     idx;
      for (int p = 0; p < NPOLES_DEF; p++) begin
        // Poles past the second have no registers and run with zero coefficients.
        if (p < 2) begin
          cr = coef_half(recur_coef[p][31:0]);
          ci = coef_half(recur_coef[p][63:32]);
          dr = coef_half(drive_coef[p][31:0]);
          di = coef_half(drive_coef[p][63:32]);
        end else begin
          cr = 0;
          ci = 0;
          dr = 0;
          di = 0;
        end
        for (int c = 0; c < 3; c++) begin
          idx = (cell_id * NPOLES_DEF + p) * 3 + c;
          ar  = acc_re[idx];
          ai  = acc_im[idx];
          e   = saved_field[cell_id * 3 + c];
          sr  = ((cr * ar) >>> 6) - ((ci * ai) >>> 6) + ((dr * e) >>> 6);
          si  = ((cr * ai) >>> 6) + ((ci * ar) >>> 6) + ((di * e) >>> 6);
          acc_re[idx] = round24(sr);
          acc_im[idx] = round24(si);
        end
      end
    endfunction

    // Updated field for one component: field plus weighted flux plus weighted memory.
    function out_item_t apply_field(int cell_id, int comp, int flux, int now);
      out_item_t want;
      longint    sum;
      int        t1, a, s, t2;
      clip_seen = 1'b0;
      t1  = round24(longint'(flux_gain) * longint'(flux));
      a   = clamp32(longint'(now) + longint'(t1));
      sum = 0;
      for (int p = 0; p < NPOLES_DEF; p++) begin
        sum += acc_re[(cell_id * NPOLES_DEF + p) * 3 + comp];
      end
      s  = clamp32(sum);
      t2 = round24(longint'(memory_gain) * longint'(s));
      want.field_new = clamp32(longint'(a) + longint'(t2));
      want.saturated = clip_seen;
      return want;
    endfunction

    function void note_item(in_item_t it);
      int cell_id, comp;
      cell_id = it.cell_index;
      comp    = it.component;
      if (cell_id >= CELLS_DEF) begin
        n_dropped++;
        return;
      end
      case (it.mode)
        MODE_SAVE: begin
          saved_field[cell_id * 3 + 0] = it.field_x;
          saved_field[cell_id * 3 + 1] = it.field_y;
          saved_field[cell_id * 3 + 2] = it.field_z;
          cell_saved[cell_id] = 1'b1;
          n_saves++;
        end
        MODE_UPDATE: begin
          update_cell(cell_id);
          n_updates++;
        end
        MODE_APPLY: begin
          if (it.component == COMP_NONE) begin
            n_dropped++;
          end else begin
            field_expected.push_back(apply_field(cell_id, comp, $signed(it.flux_value),
                                                 $signed(it.field_now)));
            n_applies++;
          end
        end
        default: n_dropped++;
      endcase
    endfunction

    function void note_error(string msg);
      n_errors++;
      if (n_errors <= 10) begin
        $display("MISMATCH at %0t: %s", $realtime, msg);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (field_expected.size() == 0) begin
        note_error($sformatf("result field_new=%0d saturated=%0b with none outstanding",
                             $signed(got.field_new), got.saturated));
        return;
      end
      want = field_expected.pop_front();
      n_checked++;
      if (got.saturated === 1'b1) n_clipped++;
      if (got.field_new !== want.field_new) begin
        note_error($sformatf("field_new expected %0d got %0d",
                             $signed(want.field_new), $signed(got.field_new)));
      end
      if (got.saturated !== want.saturated) begin
        note_error($sformatf("saturated expected %0b got %0b", want.saturated, got.saturated));
      end
    endfunction

    function int pending();
      return field_expected.size();
    endfunction

    function void close_out();
      if (field_expected.size() != 0) begin
        note_error($sformatf("%0d expected results never arrived", field_expected.size()));
      end
    endfunction
  endclass

endpackage

FILE: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rcfu_pkg::*;
  import rcfu_tb_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [2:0] REG_SPARE6  = 3'd6;
  localparam logic [2:0] REG_SPARE7  = 3'd7;

  // An accumulator update is the slowest item; this covers it with some margin.
  localparam int SETTLE_CYCLES = 10 * 3 * NPOLES_DEF + 8;
  localparam int NUM_PHASES    = 5;

  // Magnitudes for well-behaved random settings: stable poles, moderate gains.
  localparam int RECUR_MAG = 751619276;
  localparam int DRIVE_MAG = 966367641;
  localparam int GAIN_MAG  = 67108864;

  logic        clk     = 1'b0;
  logic        rst_n   = 1'b0;
  logic        start   = 1'b0;
  logic        busy;
  in_item_t    in_data = '0;
  logic        out_valid;
  out_item_t   out_data;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [5:0]  paddr   = '0;
  logic [63:0] pwdata  = '0;
  logic [63:0] prdata;
  logic        pready;

  field_update_scoreboard sb = new();
  int                     cell_pool [8];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  recursive_convolution_field_update_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Results are taken at the edge that ends their strobe cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_result(out_data);
    end
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding", sb.pending());
    $display("*** FAILED ***");
    $finish;
  end

  // One register write: setup cycle, then access until the slave is ready.
  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic load_regs(input logic [63:0] r0, r1, d0, d1, input logic [31:0] fg, mg);
    cfg_write(REG_RECUR0, r0);
    cfg_write(REG_RECUR1, r1);
    cfg_write(REG_DRIVE0, d0);
    cfg_write(REG_DRIVE1, d1);
    cfg_write(REG_FLUXG, {$urandom(), fg});
    cfg_write(REG_MEMG, {$urandom(), mg});
    // Writes past the last register must leave every setting as it was.
    cfg_write(REG_SPARE6, {$urandom(), $urandom()});
    cfg_write(REG_SPARE7, {$urandom(), $urandom()});
  endtask

  // Kind 0 keeps values within a magnitude, kind 1 takes only the extremes, others are raw.
  function automatic logic [31:0] rand_word(int kind, int mag);
    case (kind)
      0:       return $urandom_range(0, 2 * mag) - mag;
      1:       return $urandom_range(0, 1) ? Q32_MAX : Q32_MIN;
      default: return $urandom();
    endcase
  endfunction

  task automatic load_random(int kind);
    load_regs({rand_word(kind, RECUR_MAG), rand_word(kind, RECUR_MAG)},
              {rand_word(kind, RECUR_MAG), rand_word(kind, RECUR_MAG)},
              {rand_word(kind, DRIVE_MAG), rand_word(kind, DRIVE_MAG)},
              {rand_word(kind, DRIVE_MAG), rand_word(kind, DRIVE_MAG)},
              rand_word(kind, GAIN_MAG), rand_word(kind, GAIN_MAG));
  endtask

  // Offer an item after a random gap and hold it until the block takes it.
  task automatic send_item(input in_item_t it, input int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    in_data <= it;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_item(it);
  endtask

  // Stop sending, wait for every outstanding result, then let trailing work finish.
  task automatic settle();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic in_item_t mk_item(logic [1:0] mode, logic [9:0] cell_id,
                                       logic [31:0] fx, fy, fz, logic [1:0] comp,
                                       logic [31:0] flux, now);
    in_item_t it;
    it.mode       = mode;
    it.cell_index = cell_id;
    it.field_x    = fx;
    it.field_y    = fy;
    it.field_z    = fz;
    it.component  = comp;
    it.flux_value = flux;
    it.field_now  = now;
    return it;
  endfunction

  // Q8.24 value: extremes, small magnitudes within four, or any pattern.
  function automatic logic [31:0] rand_q();
    case ($urandom_range(0, 7))
      0:       return Q32_MAX;
      1:       return Q32_MIN;
      2:       return $urandom_range(0, 1) ? 32'h0 : 32'hffff_ffff;
      3, 4, 5: return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
      default: return $urandom();
    endcase
  endfunction

  // Most items hit a few cells so that their accumulators build up history.
  function automatic logic [9:0] pick_cell();
    if ($urandom_range(0, 4) == 0) return 10'($urandom_range(0, CELLS_DEF - 1));
    return 10'(cell_pool[$urandom_range(0, 7)]);
  endfunction

  // Saves, updates of saved cells and applies, with a few items the block drops.
  function automatic in_item_t rand_item();
    in_item_t it;
    int       roll;
    it = mk_item(MODE_APPLY, pick_cell(), rand_q(), rand_q(), rand_q(),
                 2'($urandom_range(0, 2)), rand_q(), rand_q());
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      it.mode = MODE_UNUSED;
    end else if (roll < 8) begin
      it.component = COMP_NONE;
    end else if (roll < 28 || (roll < 50 && !sb.cell_saved[it.cell_index])) begin
      it.mode = MODE_SAVE;
    end else if (roll < 50) begin
      it.mode = MODE_UPDATE;
    end
    return it;
  endfunction

  function automatic bit is_dropped(in_item_t it);
    return it.mode == MODE_UNUSED || (it.mode == MODE_APPLY && it.component == COMP_NONE);
  endfunction

  initial begin
    in_item_t it;
    int       quota, idle, kind, taken;

    cell_pool[0] = 0;
    cell_pool[1] = CELLS_DEF - 1;
    for (int i = 2; i < 8; i++) cell_pool[i] = $urandom_range(0, CELLS_DEF - 1);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Settings from reset: no flux weight, unit memory weight, cleared accumulators.
    send_item(mk_item(MODE_APPLY, 10'd0, '0, '0, '0, 2'd0, Q32_MAX, Q32_MAX), 0);
    send_item(mk_item(MODE_APPLY, 10'd1023, '0, '0, '0, 2'd2, Q32_MIN, Q32_MIN), 0);
    send_item(mk_item(MODE_UNUSED, 10'd5, '0, '0, '0, 2'd0, '0, '0), 0);
    send_item(mk_item(MODE_APPLY, 10'd5, '0, '0, '0, COMP_NONE, '0, '0), 0);

    // Hand-picked coefficients, including the extreme halves of one drive weight.
    settle();
    load_regs({32'h1000_0000, 32'h2000_0000}, {32'he000_0000, 32'hd000_0000},
              {32'hc000_0000, 32'h4000_0000}, {Q32_MIN, Q32_MAX},
              32'h0080_0000, 32'h0200_0000);
    send_item(mk_item(MODE_SAVE, 10'd0, Q32_MAX, Q32_MIN, '0, 2'd0, '0, '0), 0);
    send_item(mk_item(MODE_SAVE, 10'd1023, 32'hffff_ffff, 32'd1, 32'h0100_0000,
                      2'd0, '0, '0), 0);
    send_item(mk_item(MODE_UPDATE, 10'd0, '0, '0, '0, 2'd0, '0, '0), 0);
    send_item(mk_item(MODE_UPDATE, 10'd0, '0, '0, '0, 2'd0, '0, '0), 0);
    send_item(mk_item(MODE_UPDATE, 10'd1023, '0, '0, '0, 2'd0, '0, '0), 0);
    send_item(mk_item(MODE_APPLY, 10'd0, '0, '0, '0, 2'd0, 32'h0100_0000, 32'h0200_0000), 0);
    send_item(mk_item(MODE_APPLY, 10'd0, '0, '0, '0, 2'd1, Q32_MIN, Q32_MAX), 0);
    send_item(mk_item(MODE_APPLY, 10'd0, '0, '0, '0, 2'd2, Q32_MAX, Q32_MIN), 0);
    send_item(mk_item(MODE_APPLY, 10'd1023, '0, '0, '0, 2'd2, 32'hffff_ffff, '0), 0);

    // Extreme settings push the accumulators and the sums toward saturation.
    settle();
    load_regs({Q32_MAX, Q32_MAX}, {Q32_MIN, Q32_MIN}, {Q32_MIN, Q32_MAX},
              {Q32_MAX, Q32_MIN}, Q32_MAX, Q32_MIN);
    send_item(mk_item(MODE_SAVE, 10'd1, Q32_MAX, Q32_MAX, Q32_MIN, 2'd0, '0, '0), 0);
    repeat (3) send_item(mk_item(MODE_UPDATE, 10'd1, '0, '0, '0, 2'd0, '0, '0), 0);
    send_item(mk_item(MODE_APPLY, 10'd1, '0, '0, '0, 2'd0, Q32_MAX, Q32_MAX), 0);
    send_item(mk_item(MODE_APPLY, 10'd1, '0, '0, '0, 2'd1, Q32_MIN, Q32_MIN), 0);
    send_item(mk_item(MODE_APPLY, 10'd1, '0, '0, '0, 2'd2, '0, '0), 0);
    send_item(mk_item(MODE_UPDATE, 10'd0, '0, '0, '0, 2'd0, '0, '0), 0);
    send_item(mk_item(MODE_APPLY, 10'd0, '0, '0, '0, 2'd1, Q32_MIN, Q32_MAX), 0);

    // Random phases, each with its own settings and sender gap rate.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin quota = 230; idle = 0;  kind = 0; end
        1: begin quota = 230; idle = 59; kind = 0; end
        2: begin quota = 130; idle = 14; kind = 1; end
        3: begin quota = 180; idle = 0;  kind = 0; end
        default: begin quota = 180; idle = 59; kind = 2; end
      endcase
      settle();
      load_random(kind);
      taken = 0;
      while (taken < quota) begin
        it = rand_item();
        send_item(it, idle);
        if (!is_dropped(it)) taken++;
        // Now and then hold off until the block has nothing left to report.
        if ($urandom_range(0, 49) == 0) settle();
      end
    end

    settle();
    sb.close_out();
    $display("Sent %0d saves, %0d accumulator updates, %0d applies, %0d dropped items",
             sb.n_saves, sb.n_updates, sb.n_applies, sb.n_dropped);
    $display("Checked %0d updated fields (%0d clipped) over %0d settings; %0d failures",
             sb.n_checked, sb.n_clipped, NUM_PHASES + 3, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/rcfu_pkg.sv
rtl/rcfu_ram.sv
rtl/recursive_convolution_field_update_top.sv
tb/rcfu_tb_pkg.sv
tb/tb_top.sv
